FILE: design/gtr_pkg.sv
// Shared types, constants and the 5x7 font table of the glyph text rasterizer.
`default_nettype none
package gtr_pkg;

    // Field widths of the ports
    localparam int FIELD_W = 12;
    localparam int MASK_W  = 14;
    localparam int COLOR_W = 24;
    localparam int CODE_W  = 8;

    // Glyph geometry and spacing
    localparam int GLYPH_W  = 5;
    localparam int GLYPH_H  = 7;
    localparam int CHAR_GAP = 2;
    localparam int LINE_GAP = 4;

    // Character codes with a meaning of their own
    localparam logic [CODE_W-1:0] CHAR_NEWLINE  = 8'd10;
    localparam logic [CODE_W-1:0] CHAR_FIRST    = 8'd32;
    localparam logic [CODE_W-1:0] CHAR_LAST     = 8'd127;
    localparam logic [CODE_W-1:0] CHAR_QUESTION = 8'd63;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hDCF0FF;

    localparam int FONT_DEPTH = 96;

    // One glyph: five columns of seven rows, bit 0 is the top row
    typedef logic [0:GLYPH_W-1][GLYPH_H-1:0] glyph_t;
    typedef logic [6:0] font_idx_t;

    localparam glyph_t FONT_ROM [FONT_DEPTH] = '{
        '{7'h00,7'h00,7'h00,7'h00,7'h00}, '{7'h00,7'h00,7'h5F,7'h00,7'h00},
        '{7'h00,7'h07,7'h00,7'h07,7'h00}, '{7'h14,7'h7F,7'h14,7'h7F,7'h14},
        '{7'h24,7'h2A,7'h7F,7'h2A,7'h12}, '{7'h23,7'h13,7'h08,7'h64,7'h62},
        '{7'h36,7'h49,7'h55,7'h22,7'h50}, '{7'h00,7'h05,7'h03,7'h00,7'h00},
        '{7'h00,7'h1C,7'h22,7'h41,7'h00}, '{7'h00,7'h41,7'h22,7'h1C,7'h00},
        '{7'h14,7'h08,7'h3E,7'h08,7'h14}, '{7'h08,7'h08,7'h3E,7'h08,7'h08},
        '{7'h00,7'h50,7'h30,7'h00,7'h00}, '{7'h08,7'h08,7'h08,7'h08,7'h08},
        '{7'h00,7'h60,7'h60,7'h00,7'h00}, '{7'h20,7'h10,7'h08,7'h04,7'h02},
        '{7'h3E,7'h51,7'h49,7'h45,7'h3E}, '{7'h00,7'h42,7'h7F,7'h40,7'h00},
        '{7'h42,7'h61,7'h51,7'h49,7'h46}, '{7'h21,7'h41,7'h45,7'h4B,7'h31},
        '{7'h18,7'h14,7'h12,7'h7F,7'h10}, '{7'h27,7'h45,7'h45,7'h45,7'h39},
        '{7'h3C,7'h4A,7'h49,7'h49,7'h30}, '{7'h01,7'h71,7'h09,7'h05,7'h03},
        '{7'h36,7'h49,7'h49,7'h49,7'h36}, '{7'h06,7'h49,7'h49,7'h29,7'h1E},
        '{7'h00,7'h36,7'h36,7'h00,7'h00}, '{7'h00,7'h56,7'h36,7'h00,7'h00},
        '{7'h08,7'h14,7'h22,7'h41,7'h00}, '{7'h14,7'h14,7'h14,7'h14,7'h14},
        '{7'h00,7'h41,7'h22,7'h14,7'h08}, '{7'h02,7'h01,7'h51,7'h09,7'h06},
        '{7'h32,7'h49,7'h79,7'h41,7'h3E}, '{7'h7E,7'h11,7'h11,7'h11,7'h7E},
        '{7'h7F,7'h49,7'h49,7'h49,7'h36}, '{7'h3E,7'h41,7'h41,7'h41,7'h22},
        '{7'h7F,7'h41,7'h41,7'h22,7'h1C}, '{7'h7F,7'h49,7'h49,7'h49,7'h41},
        '{7'h7F,7'h09,7'h09,7'h09,7'h01}, '{7'h3E,7'h41,7'h49,7'h49,7'h7A},
        '{7'h7F,7'h08,7'h08,7'h08,7'h7F}, '{7'h00,7'h41,7'h7F,7'h41,7'h00},
        '{7'h20,7'h40,7'h41,7'h3F,7'h01}, '{7'h7F,7'h08,7'h14,7'h22,7'h41},
        '{7'h7F,7'h40,7'h40,7'h40,7'h40}, '{7'h7F,7'h02,7'h0C,7'h02,7'h7F},
        '{7'h7F,7'h04,7'h08,7'h10,7'h7F}, '{7'h3E,7'h41,7'h41,7'h41,7'h3E},
        '{7'h7F,7'h09,7'h09,7'h09,7'h06}, '{7'h3E,7'h41,7'h51,7'h21,7'h5E},
        '{7'h7F,7'h09,7'h19,7'h29,7'h46}, '{7'h46,7'h49,7'h49,7'h49,7'h31},
        '{7'h01,7'h01,7'h7F,7'h01,7'h01}, '{7'h3F,7'h40,7'h40,7'h40,7'h3F},
        '{7'h1F,7'h20,7'h40,7'h20,7'h1F}, '{7'h7F,7'h20,7'h18,7'h20,7'h7F},
        '{7'h63,7'h14,7'h08,7'h14,7'h63}, '{7'h03,7'h04,7'h78,7'h04,7'h03},
        '{7'h61,7'h51,7'h49,7'h45,7'h43}, '{7'h00,7'h7F,7'h41,7'h41,7'h00},
        '{7'h02,7'h04,7'h08,7'h10,7'h20}, '{7'h00,7'h41,7'h41,7'h7F,7'h00},
        '{7'h04,7'h02,7'h01,7'h02,7'h04}, '{7'h40,7'h40,7'h40,7'h40,7'h40},
        '{7'h00,7'h01,7'h02,7'h04,7'h00}, '{7'h20,7'h54,7'h54,7'h54,7'h78},
        '{7'h7F,7'h48,7'h44,7'h44,7'h38}, '{7'h38,7'h44,7'h44,7'h44,7'h20},
        '{7'h38,7'h44,7'h44,7'h48,7'h7F}, '{7'h38,7'h54,7'h54,7'h54,7'h18},
        '{7'h08,7'h7E,7'h09,7'h01,7'h02}, '{7'h0C,7'h52,7'h52,7'h52,7'h3E},
        '{7'h7F,7'h08,7'h04,7'h04,7'h78}, '{7'h00,7'h44,7'h7D,7'h40,7'h00},
        '{7'h20,7'h40,7'h44,7'h3D,7'h00}, '{7'h7F,7'h10,7'h28,7'h44,7'h00},
        '{7'h00,7'h41,7'h7F,7'h40,7'h00}, '{7'h7C,7'h04,7'h18,7'h04,7'h78},
        '{7'h7C,7'h08,7'h04,7'h04,7'h78}, '{7'h38,7'h44,7'h44,7'h44,7'h38},
        '{7'h7C,7'h14,7'h14,7'h14,7'h08}, '{7'h08,7'h14,7'h14,7'h18,7'h7C},
        '{7'h7C,7'h08,7'h04,7'h04,7'h08}, '{7'h48,7'h54,7'h54,7'h54,7'h20},
        '{7'h04,7'h3F,7'h44,7'h40,7'h20}, '{7'h3C,7'h40,7'h40,7'h20,7'h7C},
        '{7'h1C,7'h20,7'h40,7'h20,7'h1C}, '{7'h3C,7'h40,7'h30,7'h40,7'h3C},
        '{7'h44,7'h28,7'h10,7'h28,7'h44}, '{7'h0C,7'h50,7'h50,7'h50,7'h3C},
        '{7'h44,7'h64,7'h54,7'h4C,7'h44}, '{7'h08,7'h36,7'h41,7'h41,7'h00},
        '{7'h00,7'h00,7'h7F,7'h00,7'h00}, '{7'h00,7'h41,7'h41,7'h36,7'h08},
        '{7'h10,7'h08,7'h08,7'h10,7'h08}, '{7'h00,7'h00,7'h00,7'h00,7'h00}
    };

endpackage
`default_nettype wire

FILE: design/glyph_text_rasterizer.sv
// Top level of the glyph text rasterizer: character beats in, scaled pixel columns out.
`default_nettype none
// A printable character occupies the block for 5*SCALE column beats, one column beat
// per cycle while m_ready does not stall the output register, and the next character
// is taken in the cycle of its last column. A newline emits nothing. The glyph is
// fetched from the font ROM into glyph_reg in the cycle of the accept; its first
// column moves from there into the output register once that register is free.
// Cursor, line and line start are updated at the accept of each character, and all
// coordinates saturate at 2^COORD_BITS-1. The text color is written through the cfg
// channel, which is always ready; write it only while no text is in flight.
module glyph_text_rasterizer #(
    parameter int SCALE      = 2,
    parameter int COORD_BITS = 12
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // register write channel
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [gtr_pkg::COLOR_W-1:0]   cfg_data,
    // character channel
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [gtr_pkg::CODE_W-1:0]    s_char_code,
    input  wire                          s_new_string,
    input  wire [gtr_pkg::FIELD_W-1:0]   s_origin_x,
    input  wire [gtr_pkg::FIELD_W-1:0]   s_origin_y,
    // pixel column channel
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [gtr_pkg::FIELD_W-1:0]  m_pixel_x,
    output logic [gtr_pkg::FIELD_W-1:0]  m_pixel_y,
    output logic [gtr_pkg::MASK_W-1:0]   m_column_mask,
    output logic [gtr_pkg::COLOR_W-1:0]  m_color,
    output logic                         m_last_column
);

    localparam int CW         = COORD_BITS;
    localparam int FW         = gtr_pkg::FIELD_W;
    localparam int XW         = (CW > FW) ? CW : FW;
    localparam int SXW        = (SCALE > 1) ? $clog2(SCALE) : 1;
    localparam int CHAR_STEP  = gtr_pkg::GLYPH_W * SCALE + gtr_pkg::CHAR_GAP;
    localparam int LINE_STEP  = gtr_pkg::GLYPH_H * SCALE + gtr_pkg::LINE_GAP;
    localparam logic [CW-1:0]  CMAX     = {CW{1'b1}};
    localparam logic [2:0]     LAST_COL = 3'(gtr_pkg::GLYPH_W - 1);
    localparam logic [SXW-1:0] SX_LAST  = SXW'(SCALE - 1);

    // saturating coordinate step
    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [5:0] b);
        logic [CW:0] sum;
        sum = {1'b0, a} + (CW+1)'(b);
        return sum[CW] ? CMAX : sum[CW-1:0];
    endfunction

    // clamp a 12-bit origin to the coordinate range
    function automatic logic [CW-1:0] sat_origin(input logic [FW-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        return (w > XW'(CMAX)) ? CMAX : CW'(w);
    endfunction

    logic [gtr_pkg::COLOR_W-1:0] ink_color_reg;
    logic [CW-1:0]               cursor_x_reg, cursor_x_next;
    logic [CW-1:0]               line_y_reg, line_y_next;
    logic [CW-1:0]               line_start_reg, line_start_next;

    logic                        busy_reg;
    gtr_pkg::glyph_t             glyph_reg;
    logic [CW:0]                 xpos_reg;
    logic [CW-1:0]               row_y_reg;
    logic [2:0]                  col_reg;
    logic [SXW-1:0]              sx_reg;

    logic                        s_accept, is_newline, out_load, gen_last;
    logic [CW-1:0]               org_x, org_y, cur_base, ly_base, ls_base, px_sat;
    logic [gtr_pkg::CODE_W-1:0]  code_eff;
    gtr_pkg::font_idx_t          rom_idx;
    logic [gtr_pkg::GLYPH_H-1:0] col_bits;
    logic [gtr_pkg::MASK_W-1:0]  mask;

    assign cfg_ready = 1'b1;

    // handshake control
    assign gen_last = (col_reg == LAST_COL) && (sx_reg == SX_LAST);
    assign out_load = busy_reg && (!m_valid || m_ready);
    assign s_ready  = !busy_reg || (out_load && gen_last);
    assign s_accept = s_valid && s_ready;
    assign is_newline = (s_char_code == gtr_pkg::CHAR_NEWLINE);

    // state as seen by the incoming character
    assign org_x    = sat_origin(s_origin_x);
    assign org_y    = sat_origin(s_origin_y);
    assign cur_base = s_new_string ? org_x : cursor_x_reg;
    assign ly_base  = s_new_string ? org_y : line_y_reg;
    assign ls_base  = s_new_string ? org_x : line_start_reg;

    always_comb begin
        line_start_next = ls_base;
        if (is_newline) begin
            cursor_x_next = ls_base;
            line_y_next   = sat_add(ly_base, 6'(LINE_STEP));
        end else begin
            cursor_x_next = sat_add(cur_base, 6'(CHAR_STEP));
            line_y_next   = ly_base;
        end
    end

    // font ROM address; codes outside the table draw as a question mark
    assign code_eff = (s_char_code < gtr_pkg::CHAR_FIRST || s_char_code > gtr_pkg::CHAR_LAST)
                      ? gtr_pkg::CHAR_QUESTION : s_char_code;
    assign rom_idx  = 7'(code_eff - gtr_pkg::CHAR_FIRST);

    // vertical scaling of the current column
    assign col_bits = glyph_reg[col_reg];
    always_comb begin
        mask = '0;
        for (int r = 0; r < gtr_pkg::GLYPH_H; r++) begin
            for (int s = 0; s < SCALE; s++) begin
                if (r * SCALE + s < gtr_pkg::MASK_W) begin
                    mask[r * SCALE + s] = col_bits[r];
                end
            end
        end
    end

    assign px_sat = xpos_reg[CW] ? CMAX : xpos_reg[CW-1:0];

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ink_color_reg <= gtr_pkg::COLOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            ink_color_reg <= cfg_data;
        end
    end

    // text position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg   <= '0;
            line_y_reg     <= '0;
            line_start_reg <= '0;
        end else if (s_accept) begin
            cursor_x_reg   <= cursor_x_next;
            line_y_reg     <= line_y_next;
            line_start_reg <= line_start_next;
        end
    end

    // font ROM, registered read
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            glyph_reg <= gtr_pkg::FONT_ROM[rom_idx];
        end
    end

    // column walker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
            sx_reg   <= '0;
        end else begin
            if (out_load) begin
                if (sx_reg == SX_LAST) begin
                    sx_reg  <= '0;
                    col_reg <= col_reg + 3'd1;
                end else begin
                    sx_reg  <= sx_reg + SXW'(1);
                end
                if (gen_last) begin
                    busy_reg <= 1'b0;
                end
            end
            if (s_accept) begin
                busy_reg <= !is_newline;
                col_reg  <= '0;
                sx_reg   <= '0;
            end
        end
    end

    // column position payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            xpos_reg  <= {1'b0, cur_base};
            row_y_reg <= ly_base;
        end else if (out_load) begin
            xpos_reg  <= xpos_reg + (CW+1)'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pixel_x     <= FW'(px_sat);
            m_pixel_y     <= FW'(row_y_reg);
            m_column_mask <= mask;
            m_color       <= ink_color_reg;
            m_last_column <= gen_last;
        end
    end

    // a printable character starts the column walk
    a_start_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && !is_newline |=> busy_reg && col_reg == '0 && sx_reg == '0)
        else $error("column walk did not start after a character beat");

    // the walker never runs past the last glyph column
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> col_reg <= LAST_COL)
        else $error("glyph column index out of range");

    // the last column ends the walk unless a new character came in with it
    a_walk_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && gen_last && !s_accept |=> !busy_reg)
        else $error("column walk continued past the last column");

    // the walk keeps running until its last column beat
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && !gen_last |=> busy_reg)
        else $error("walker stopped before the last column");

endmodule
`default_nettype wire

FILE: sim/gtr_checker.sv
// Checker for the glyph text rasterizer: predicts every pixel column beat and compares it.
module gtr_checker #(
    parameter int SCALE      = 2,
    parameter int COORD_BITS = 12
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_valid,
    input  wire                                cfg_ready,
    input  wire [gtr_pkg::COLOR_W-1:0]         cfg_data,
    input  wire                                s_valid,
    input  wire                                s_ready,
    input  wire [gtr_pkg::CODE_W-1:0]          s_char_code,
    input  wire                                s_new_string,
    input  wire [gtr_pkg::FIELD_W-1:0]         s_origin_x,
    input  wire [gtr_pkg::FIELD_W-1:0]         s_origin_y,
    input  wire                                m_valid,
    input  wire                                m_ready,
    input  wire [gtr_pkg::FIELD_W-1:0]         m_pixel_x,
    input  wire [gtr_pkg::FIELD_W-1:0]         m_pixel_y,
    input  wire [gtr_pkg::MASK_W-1:0]          m_column_mask,
    input  wire [gtr_pkg::COLOR_W-1:0]         m_color,
    input  wire                                m_last_column,
    output int unsigned                        fail_count,
    output int unsigned                        pending_cols,
    output int unsigned                        checked_cols
);

    localparam int GL_COLS    = 5;
    localparam int GL_ROWS    = 7;
    localparam int CHAR_ADV   = GL_COLS * SCALE + 2;
    localparam int LINE_ADV   = GL_ROWS * SCALE + 4;
    localparam int REPORT_MAX = 10;
    localparam longint unsigned COORD_TOP = (64'd1 << COORD_BITS) - 64'd1;

    typedef struct packed {
        logic [gtr_pkg::FIELD_W-1:0] px;
        logic [gtr_pkg::FIELD_W-1:0] py;
        logic [gtr_pkg::MASK_W-1:0]  mask;
        logic [gtr_pkg::COLOR_W-1:0] color;
        logic                        last_col;
    } column_beat_t;

    // Font columns, first column in the top byte, bit 0 of each byte is the top row
    localparam logic [39:0] FONT_COLS [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
        40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0836414100, 40'h00007F0000, 40'h0041413608, 40'h1008081008,
        40'h0000000000
    };

    // Shadow of the text color and of the pen position
    logic [gtr_pkg::COLOR_W-1:0] color_reg;
    longint unsigned             cur_x;
    longint unsigned             row_y;
    longint unsigned             line_x;
    column_beat_t                expected_cols [$];

    function automatic longint unsigned clamp_coord(input longint unsigned v);
        return (v > COORD_TOP) ? COORD_TOP : v;
    endfunction

    // Each font row becomes SCALE adjacent mask bits
    function automatic logic [gtr_pkg::MASK_W-1:0] stretch_rows(input logic [6:0] bits);
        logic [31:0] m;
        int          r;
        int          s;
        m = '0;
        for (r = 0; r < GL_ROWS; r++) begin
            if (bits[r]) begin
                for (s = 0; s < SCALE; s++) m[r*SCALE+s] = 1'b1;
            end
        end
        return m[gtr_pkg::MASK_W-1:0];
    endfunction

    // Update the pen for one character and queue the columns it draws
    task automatic rasterize(input logic [gtr_pkg::CODE_W-1:0] code_in, input logic fresh,
                             input logic [gtr_pkg::FIELD_W-1:0] ox,
                             input logic [gtr_pkg::FIELD_W-1:0] oy);
        logic [gtr_pkg::CODE_W-1:0] code;
        logic [39:0]                glyph;
        logic [gtr_pkg::MASK_W-1:0] mask;
        column_beat_t               beat;
        int                         col;
        int                         sx;
        int                         n;
        code = code_in;
        if (fresh) begin
            line_x = clamp_coord(64'(ox));
            cur_x  = line_x;
            row_y  = clamp_coord(64'(oy));
        end
        // newline moves the pen and draws nothing
        if (code == gtr_pkg::CHAR_NEWLINE) begin
            row_y = clamp_coord(row_y + LINE_ADV);
            cur_x = line_x;
            return;
        end
        if (code < gtr_pkg::CHAR_FIRST || code > gtr_pkg::CHAR_LAST)
            code = gtr_pkg::CHAR_QUESTION;
        glyph = FONT_COLS[int'(code) - int'(gtr_pkg::CHAR_FIRST)];
        n = 0;
        for (col = 0; col < GL_COLS; col++) begin
            mask = stretch_rows(glyph[32-8*col +: 7]);
            for (sx = 0; sx < SCALE; sx++) begin
                beat.px       = gtr_pkg::FIELD_W'(clamp_coord(cur_x + col * SCALE + sx));
                beat.py       = gtr_pkg::FIELD_W'(row_y);
                beat.mask     = mask;
                beat.color    = color_reg;
                beat.last_col = (n == GL_COLS * SCALE - 1);
                expected_cols.push_back(beat);
                n++;
            end
        end
        cur_x = clamp_coord(cur_x + CHAR_ADV);
    endtask

    // Output beats are checked before the input beat of the same edge is predicted
    always @(posedge aclk) begin
        column_beat_t want;
        column_beat_t got;
        if (!aresetn) begin
            color_reg = 24'hDCF0FF;
            cur_x     = 0;
            row_y     = 0;
            line_x    = 0;
            expected_cols.delete();
            fail_count   <= 0;
            pending_cols <= 0;
            checked_cols <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_pixel_x, m_pixel_y, m_column_mask, m_color, m_last_column};
                if (expected_cols.size() == 0) begin
                    if (fail_count < REPORT_MAX)
                        $display("unexpected column beat x=%0d y=%0d mask=%h color=%h last=%b",
                                 got.px, got.py, got.mask, got.color, got.last_col);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_cols.pop_front();
                    if (want !== got) begin
                        if (fail_count < REPORT_MAX) begin
                            $display("column beat %0d: expected x=%0d y=%0d mask=%h color=%h last=%b",
                                     checked_cols, want.px, want.py, want.mask, want.color,
                                     want.last_col);
                            $display("    actual x=%0d y=%0d mask=%h color=%h last=%b",
                                     got.px, got.py, got.mask, got.color, got.last_col);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
                checked_cols <= checked_cols + 1;
            end
            if (cfg_valid && cfg_ready)
                color_reg = cfg_data;
            if (s_valid && s_ready)
                rasterize(s_char_code, s_new_string, s_origin_x, s_origin_y);
            pending_cols <= expected_cols.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top: drives text and color writes into the rasterizer and gives the verdict.
module tb;

    localparam int SCALE            = 2;
    localparam int COORD_BITS       = 12;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int RANDOM_PER_PHASE = 116;

    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         cfg_valid     = 1'b0;
    logic [gtr_pkg::COLOR_W-1:0]  cfg_data      = '0;
    logic                         s_valid       = 1'b0;
    logic [gtr_pkg::CODE_W-1:0]   s_char_code   = '0;
    logic                         s_new_string  = 1'b0;
    logic [gtr_pkg::FIELD_W-1:0]  s_origin_x    = '0;
    logic [gtr_pkg::FIELD_W-1:0]  s_origin_y    = '0;
    logic                         m_ready       = 1'b0;
    wire                          cfg_ready;
    wire                          s_ready;
    wire                          m_valid;
    wire  [gtr_pkg::FIELD_W-1:0]  m_pixel_x;
    wire  [gtr_pkg::FIELD_W-1:0]  m_pixel_y;
    wire  [gtr_pkg::MASK_W-1:0]   m_column_mask;
    wire  [gtr_pkg::COLOR_W-1:0]  m_color;
    wire                          m_last_column;

    int unsigned fail_count;
    int unsigned pending_cols;
    int unsigned checked_cols;
    int unsigned cycle_count   = 0;
    int unsigned tx_idle_pct   = 16;
    int unsigned rx_idle_pct   = 74;
    int unsigned chars_sent    = 0;
    int unsigned newlines_sent = 0;
    int unsigned odd_codes     = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    glyph_text_rasterizer #(.SCALE(SCALE), .COORD_BITS(COORD_BITS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_char_code(s_char_code),
        .s_new_string(s_new_string), .s_origin_x(s_origin_x), .s_origin_y(s_origin_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel_x(m_pixel_x), .m_pixel_y(m_pixel_y),
        .m_column_mask(m_column_mask), .m_color(m_color), .m_last_column(m_last_column)
    );

    gtr_checker #(.SCALE(SCALE), .COORD_BITS(COORD_BITS)) u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_char_code(s_char_code),
        .s_new_string(s_new_string), .s_origin_x(s_origin_x), .s_origin_y(s_origin_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel_x(m_pixel_x), .m_pixel_y(m_pixel_y),
        .m_column_mask(m_column_mask), .m_color(m_color), .m_last_column(m_last_column),
        .fail_count(fail_count), .pending_cols(pending_cols), .checked_cols(checked_cols)
    );

    // Receiver backpressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // One character beat, with random idle cycles ahead of it
    task automatic put_char(input logic [gtr_pkg::CODE_W-1:0] code, input logic fresh,
                            input logic [gtr_pkg::FIELD_W-1:0] ox,
                            input logic [gtr_pkg::FIELD_W-1:0] oy);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_char_code  <= code;
        s_new_string <= fresh;
        s_origin_x   <= ox;
        s_origin_y   <= oy;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
        if (code == gtr_pkg::CHAR_NEWLINE)
            newlines_sent++;
        else if (code < gtr_pkg::CHAR_FIRST || code > gtr_pkg::CHAR_LAST)
            odd_codes++;
    endtask

    // Mostly printable text, some newlines, blanks and codes outside the font
    task automatic random_char();
        logic [gtr_pkg::CODE_W-1:0]  code;
        logic                        fresh;
        logic [gtr_pkg::FIELD_W-1:0] ox;
        logic [gtr_pkg::FIELD_W-1:0] oy;
        int unsigned                 roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            code = gtr_pkg::CODE_W'($urandom_range(32, 126));
        else if (roll < 80)
            code = gtr_pkg::CHAR_NEWLINE;
        else if (roll < 85)
            code = gtr_pkg::CHAR_LAST;
        else if (roll < 92)
            code = gtr_pkg::CODE_W'($urandom_range(0, 31));
        else
            code = gtr_pkg::CODE_W'($urandom_range(128, 255));
        fresh = ($urandom_range(0, 99) < 12);
        roll  = $urandom_range(0, 99);
        if (roll < 60) begin
            ox = gtr_pkg::FIELD_W'($urandom_range(0, 1023));
            oy = gtr_pkg::FIELD_W'($urandom_range(0, 1023));
        end else if (roll < 80) begin
            // near the right and bottom edges, where coordinates clamp
            ox = gtr_pkg::FIELD_W'($urandom_range(4000, 4095));
            oy = gtr_pkg::FIELD_W'($urandom_range(3900, 4095));
        end else begin
            ox = gtr_pkg::FIELD_W'($urandom);
            oy = gtr_pkg::FIELD_W'($urandom);
        end
        put_char(code, fresh, ox, oy);
    endtask

    // Stop sending, wait for every expected column, then idle for DRAIN_CYCLES before going on
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_cols != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_color(input logic [gtr_pkg::COLOR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed text at the reset color
        put_char("A", 1'b1, 12'd0, 12'd0);
        put_char(" ", 1'b0, 12'd0, 12'd0);
        put_char(gtr_pkg::CHAR_LAST, 1'b0, 12'd0, 12'd0);
        put_char(8'd0, 1'b0, 12'd0, 12'd0);
        put_char(8'd31, 1'b0, 12'd0, 12'd0);
        put_char(8'd128, 1'b0, 12'd0, 12'd0);
        put_char(8'd255, 1'b0, 12'd0, 12'd0);
        put_char("~", 1'b0, 12'd0, 12'd0);
        put_char(gtr_pkg::CHAR_NEWLINE, 1'b0, 12'd0, 12'd0);
        put_char("!", 1'b0, 12'd0, 12'd0);
        // newline right after loading an origin
        put_char(gtr_pkg::CHAR_NEWLINE, 1'b1, 12'd100, 12'd200);
        put_char("#", 1'b0, 12'd0, 12'd0);
        // clamping at the far corner
        put_char("W", 1'b1, 12'hFFF, 12'hFFF);
        put_char(gtr_pkg::CHAR_NEWLINE, 1'b0, 12'd0, 12'd0);
        put_char("B", 1'b0, 12'd0, 12'd0);
        put_char("@", 1'b1, 12'd4090, 12'd4080);
        put_char("M", 1'b0, 12'd0, 12'd0);
        put_char("Z", 1'b1, 12'hAAA, 12'h555);
        put_char("z", 1'b1, 12'h555, 12'hAAA);
        put_char(gtr_pkg::CHAR_NEWLINE, 1'b0, 12'd0, 12'd0);
        put_char(8'd9, 1'b0, 12'd0, 12'd0);
        put_char("0", 1'b0, 12'd0, 12'd0);
        settle();

        // Fast sender, heavily stalled receiver, black text
        write_color(24'h000000);
        repeat (RANDOM_PER_PHASE) random_char();
        settle();

        // Roles swapped, white text
        tx_idle_pct = 74;
        rx_idle_pct = 16;
        write_color(24'hFFFFFF);
        repeat (RANDOM_PER_PHASE) random_char();
        settle();

        // Full rate, random color
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_color(gtr_pkg::COLOR_W'($urandom));
        repeat (RANDOM_PER_PHASE) random_char();
        settle();

        $display("%0d characters sent (%0d newlines, %0d drawn as question marks), %0d columns",
                 chars_sent, newlines_sent, odd_codes, checked_cols);
        $display("reset, black, white and random colors; both stall mixes and a full-rate run");
        if (fail_count == 0 && pending_cols == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
